FILE: src/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared widths, constants, the quarter-wave sine table builder and the beat types
// used by the Euler angle to rotation matrix block.
// ----------------------------------------------------------------------------
package e2r_pkg;

   localparam int ANGLE_W         = 18;
   localparam int OUT_W           = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int SINE_TABLE_BITS = 10;
   localparam int TAB_N           = 1 << SINE_TABLE_BITS;
   localparam int TAB_W           = 15;
   localparam int TRIG_W          = 16;
   localparam int ONE_Q14         = 16384;

   localparam longint FULL_TURN = longint'(360) << ANGLE_FRAC_BITS;
   localparam longint QUARTER   = longint'(90) << ANGLE_FRAC_BITS;
   localparam int WRAP_W  = 24;
   localparam int P_W     = $clog2(QUARTER);
   localparam int V_W     = $clog2(QUARTER * (TAB_N + 1));
   localparam longint RECIP = ((longint'(1) << V_W) + QUARTER - 1) / QUARTER;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int IDX_W   = SINE_TABLE_BITS + 1;
   localparam int Q0_W    = SINE_TABLE_BITS + 2;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [TAB_W-1:0] sine_table_type [0:TAB_N];

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
   } trig_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] r11;
      logic signed [OUT_W-1:0] r12;
      logic signed [OUT_W-1:0] r13;
      logic signed [OUT_W-1:0] r21;
      logic signed [OUT_W-1:0] r22;
      logic signed [OUT_W-1:0] r23;
      logic signed [OUT_W-1:0] r31;
      logic signed [OUT_W-1:0] r32;
      logic signed [OUT_W-1:0] r33;
   } matrix_type;

   // shift-subtract quotient, used while building the table
   function automatic longint unsigned udiv(input longint unsigned n,
                                            input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // taylor series in q30, evaluated at elaboration only
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint r;
      for (int i = 0; i <= TAB_N; i++) begin
         x    = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            term = udiv(term, 64'((2 * k) * (2 * k + 1)));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         r = (sum + 32768) >>> 16;
         if (r > ONE_Q14) r = ONE_Q14;
         tab[i] = TAB_W'(r);
      end
      return tab;
   endfunction

endpackage

FILE: src/e2r_if.sv
// ----------------------------------------------------------------------------
// e2r_if
// Valid/ready channels for angle triples and matrix results.
// ----------------------------------------------------------------------------
interface e2r_req_if;
   import e2r_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_x;
   logic signed [ANGLE_W-1:0] angle_y;
   logic signed [ANGLE_W-1:0] angle_z;
   modport source (output valid, angle_x, angle_y, angle_z, input ready);
   modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2r_rsp_if;
   import e2r_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] r11;
   logic signed [OUT_W-1:0] r12;
   logic signed [OUT_W-1:0] r13;
   logic signed [OUT_W-1:0] r21;
   logic signed [OUT_W-1:0] r22;
   logic signed [OUT_W-1:0] r23;
   logic signed [OUT_W-1:0] r31;
   logic signed [OUT_W-1:0] r32;
   logic signed [OUT_W-1:0] r33;
   modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   input ready);
   modport sink (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                 output ready);
endinterface

FILE: src/euler_to_rotation_matrix_top.sv
// an accepted req beat runs through the lane registers, then the merge registers, to its rsp beat
// throughput: one angle triple per cycle; the pipeline holds while rsp stalls
// the last merge stage is the output register
// reset: synchronous, active high; clears the stage valid bits only
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// Three angle lanes feed a merge stage that builds the X*Y*Z rotation matrix.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top
   import e2r_pkg::*;
(
   input logic      clock,
   input logic      reset,
   e2r_req_if.sink  req,
   e2r_rsp_if.source rsp
);

   localparam int DEPTH = 7;

   logic             pipe_en;
   logic [DEPTH-1:0] valid_ff, valid_in;
   trig_type         tx, ty, tz;
   matrix_type       mat;

   assign pipe_en  = !valid_ff[DEPTH-1] || rsp.ready;
   assign req.ready = pipe_en;
   assign valid_in = {valid_ff[DEPTH-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   e2r_lane u_lane_x (.clock(clock), .en(pipe_en), .angle(req.angle_x), .trig(tx));
   e2r_lane u_lane_y (.clock(clock), .en(pipe_en), .angle(req.angle_y), .trig(ty));
   e2r_lane u_lane_z (.clock(clock), .en(pipe_en), .angle(req.angle_z), .trig(tz));

   e2r_merge u_merge (
      .clock(clock), .en(pipe_en), .tx(tx), .ty(ty), .tz(tz), .mat(mat)
   );

   assign rsp.valid = valid_ff[DEPTH-1];
   assign rsp.r11   = mat.r11;
   assign rsp.r12   = mat.r12;
   assign rsp.r13   = mat.r13;
   assign rsp.r21   = mat.r21;
   assign rsp.r22   = mat.r22;
   assign rsp.r23   = mat.r23;
   assign rsp.r31   = mat.r31;
   assign rsp.r32   = mat.r32;
   assign rsp.r33   = mat.r33;

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(valid_ff)) else $error("pipeline moved while stalled");

   a_r11_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.r11 <= 16'sd16384 && rsp.r11 >= -16'sd16384))
      else $error("r11 out of range");

   a_r22_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.r22 <= 16'sd16384 && rsp.r22 >= -16'sd16384))
      else $error("r22 out of range");
`endif

endmodule

FILE: src/e2r_lane.sv
// ----------------------------------------------------------------------------
// e2r_lane
// One angle lane: wrap to a turn, quadrant split, table index, table read
// and quadrant sign fix. Four pipeline stages, all advanced by en.
// ----------------------------------------------------------------------------
module e2r_lane
   import e2r_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [ANGLE_W-1:0] angle,
   output trig_type                  trig
);

   localparam sine_table_type SINE_ROM = build_sine_table();
   localparam logic signed [WRAP_W-1:0] FULL_S = WRAP_W'(FULL_TURN);
   localparam logic signed [WRAP_W-1:0] Q1_S   = WRAP_W'(QUARTER);
   localparam logic signed [WRAP_W-1:0] Q2_S   = WRAP_W'(2 * QUARTER);
   localparam logic signed [WRAP_W-1:0] Q3_S   = WRAP_W'(3 * QUARTER);
   localparam int PROD_W = V_W + RECIP_W;
   localparam int REM_W  = V_W + 3;

   logic [1:0]       quad1_ff, quad1_in, quad2_ff, quad3_ff;
   logic [P_W-1:0]   p_ff, p_in;
   logic [V_W-1:0]   v_ff, v_in;
   logic [Q0_W-1:0]  q0_ff, q0_in;
   logic [TAB_W-1:0] ti_ff, tn_ff;
   logic [IDX_W-1:0] idx_in, idxn_in;
   trig_type         trig_ff, trig_in;

   logic signed [WRAP_W-1:0] a_w, r_w;
   logic [PROD_W-1:0]        prod;
   logic signed [REM_W-1:0]  rem;
   logic [Q0_W-1:0]          q0_fix;

   // reduce to [0, 360) and split into quadrant and offset
   always_comb begin
      a_w = {{(WRAP_W-ANGLE_W){angle[ANGLE_W-1]}}, angle};
      r_w = a_w;
      if (r_w < 0) r_w = r_w + FULL_S;
      if (r_w < 0) r_w = r_w + FULL_S;
      if (r_w >= FULL_S) r_w = r_w - FULL_S;
      if (r_w >= Q3_S) begin
         quad1_in = 2'd3;
         p_in     = P_W'(r_w - Q3_S);
      end else if (r_w >= Q2_S) begin
         quad1_in = 2'd2;
         p_in     = P_W'(r_w - Q2_S);
      end else if (r_w >= Q1_S) begin
         quad1_in = 2'd1;
         p_in     = P_W'(r_w - Q1_S);
      end else begin
         quad1_in = 2'd0;
         p_in     = P_W'(r_w);
      end
   end

   // index = round(p * n / quarter) via reciprocal multiply
   always_comb begin
      v_in  = (V_W'(p_ff) << SINE_TABLE_BITS) + V_W'(QUARTER / 2);
      prod  = PROD_W'(v_in) * PROD_W'(RECIP);
      q0_in = Q0_W'(prod >> V_W);
   end

   // estimate may be one high
   always_comb begin
      rem    = $signed(REM_W'(v_ff)) - $signed(REM_W'(longint'(q0_ff) * QUARTER));
      q0_fix = (rem < 0) ? q0_ff - Q0_W'(1) : q0_ff;
      if (q0_fix > Q0_W'(TAB_N)) q0_fix = Q0_W'(TAB_N);
      idx_in  = IDX_W'(q0_fix);
      idxn_in = IDX_W'(TAB_N) - idx_in;
   end

   always_comb begin
      case (quad3_ff)
         2'd0: begin
            trig_in.s = TRIG_W'(ti_ff);
            trig_in.c = TRIG_W'(tn_ff);
         end
         2'd1: begin
            trig_in.s = TRIG_W'(tn_ff);
            trig_in.c = -TRIG_W'(ti_ff);
         end
         2'd2: begin
            trig_in.s = -TRIG_W'(ti_ff);
            trig_in.c = -TRIG_W'(tn_ff);
         end
         default: begin
            trig_in.s = -TRIG_W'(tn_ff);
            trig_in.c = TRIG_W'(ti_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad1_ff <= quad1_in;
         p_ff     <= p_in;
         quad2_ff <= quad1_ff;
         v_ff     <= v_in;
         q0_ff    <= q0_in;
         quad3_ff <= quad2_ff;
         ti_ff    <= SINE_ROM[idx_in];
         tn_ff    <= SINE_ROM[idxn_in];
         trig_ff  <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

FILE: src/e2r_merge.sv
// ----------------------------------------------------------------------------
// e2r_merge
// Combines the three lanes' sine/cosine pairs into the X*Y*Z matrix:
// pair products, triple products, then round and saturate to Q2.14.
// ----------------------------------------------------------------------------
module e2r_merge
   import e2r_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  trig_type   tx,
   input  trig_type   ty,
   input  trig_type   tz,
   output matrix_type mat
);

   localparam int P2_W = 2 * TRIG_W;
   localparam int P3_W = 3 * TRIG_W;
   localparam int SW   = P3_W + 2;

   function automatic logic signed [OUT_W-1:0] finish(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = (v + (SW'(1) <<< 27)) >>> 28;
      if (t > SW'(ONE_Q14)) t = SW'(ONE_Q14);
      if (t < -SW'(ONE_Q14)) t = -SW'(ONE_Q14);
      return OUT_W'(t);
   endfunction

   logic signed [P2_W-1:0] sxsy_ff, cxsy_ff, cycz_ff, cysz_ff, sxcy_ff, cxcy_ff;
   logic signed [P2_W-1:0] cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   logic signed [TRIG_W-1:0] sy_ff, cz_ff, sz_ff;

   logic signed [P3_W-1:0] sxsycz_ff, sxsysz_ff, cxsycz_ff, cxsysz_ff;
   logic signed [P2_W-1:0] cycz2_ff, cysz2_ff, sxcy2_ff, cxcy2_ff;
   logic signed [P2_W-1:0] cxsz2_ff, cxcz2_ff, sxsz2_ff, sxcz2_ff;
   logic signed [TRIG_W-1:0] sy2_ff;

   matrix_type mat_ff, mat_in;

   always_comb begin
      mat_in.r11 = finish(SW'(cycz2_ff) <<< 14);
      mat_in.r12 = finish(-(SW'(cysz2_ff) <<< 14));
      mat_in.r13 = finish(SW'(sy2_ff) <<< 28);
      mat_in.r21 = finish(SW'(sxsycz_ff) + (SW'(cxsz2_ff) <<< 14));
      mat_in.r22 = finish(-SW'(sxsysz_ff) + (SW'(cxcz2_ff) <<< 14));
      mat_in.r23 = finish(-(SW'(sxcy2_ff) <<< 14));
      mat_in.r31 = finish(-SW'(cxsycz_ff) + (SW'(sxsz2_ff) <<< 14));
      mat_in.r32 = finish(SW'(cxsysz_ff) + (SW'(sxcz2_ff) <<< 14));
      mat_in.r33 = finish(SW'(cxcy2_ff) <<< 14);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sxsy_ff <= tx.s * ty.s;
         cxsy_ff <= tx.c * ty.s;
         cycz_ff <= ty.c * tz.c;
         cysz_ff <= ty.c * tz.s;
         sxcy_ff <= tx.s * ty.c;
         cxcy_ff <= tx.c * ty.c;
         cxsz_ff <= tx.c * tz.s;
         cxcz_ff <= tx.c * tz.c;
         sxsz_ff <= tx.s * tz.s;
         sxcz_ff <= tx.s * tz.c;
         sy_ff   <= ty.s;
         cz_ff   <= tz.c;
         sz_ff   <= tz.s;

         sxsycz_ff <= P3_W'(sxsy_ff) * P3_W'(cz_ff);
         sxsysz_ff <= P3_W'(sxsy_ff) * P3_W'(sz_ff);
         cxsycz_ff <= P3_W'(cxsy_ff) * P3_W'(cz_ff);
         cxsysz_ff <= P3_W'(cxsy_ff) * P3_W'(sz_ff);
         cycz2_ff  <= cycz_ff;
         cysz2_ff  <= cysz_ff;
         sxcy2_ff  <= sxcy_ff;
         cxcy2_ff  <= cxcy_ff;
         cxsz2_ff  <= cxsz_ff;
         cxcz2_ff  <= cxcz_ff;
         sxsz2_ff  <= sxsz_ff;
         sxcz2_ff  <= sxcz_ff;
         sy2_ff    <= sy_ff;

         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;

endmodule

FILE: tb/euler_to_rotation_matrix_top_test.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top_test
// Drives angle triples into the rotation matrix block with random idling on
// both sides and checks each matrix beat against an in-bench predictor.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top_test;
   import e2r_pkg::*;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] ax;
      logic signed [ANGLE_W-1:0] ay;
      logic signed [ANGLE_W-1:0] az;
   } angles_type;

   localparam int MAX_ANGLE = 92160;

   logic clock = 1'b0;
   logic reset = 1'b1;

   e2r_req_if req ();
   e2r_rsp_if rsp ();

   euler_to_rotation_matrix_top dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   longint     quarter_sine [0:TAB_N];
   angles_type pending_angles [$];
   matrix_type expected_matrices [$];
   int         mismatch_count = 0;
   bit         stimulus_done = 0;
   bit         calm = 0;
   int         send_gap = 0;
   int         recv_gap = 0;

   function automatic longint sine_entry(longint unsigned i);
      longint unsigned x, x2, term;
      longint sum, r;
      x = (i * HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         term = (term * x2) >> 30;
         term = term / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + 32768) / 65536;
      if (r > ONE_Q14) r = ONE_Q14;
      return r;
   endfunction

   function automatic void angle_trig(input logic signed [ANGLE_W-1:0] ang,
                                      output longint s, output longint c);
      longint a, r, p, q, idx, ti, tn;
      a = longint'(ang);
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      q = (r / QUARTER) % 4;
      p = r % QUARTER;
      idx = (p * TAB_N + QUARTER / 2) / QUARTER;
      if (idx > TAB_N) idx = TAB_N;
      ti = quarter_sine[idx];
      tn = quarter_sine[TAB_N - idx];
      case (q)
         0: begin s = ti;  c = tn;  end
         1: begin s = tn;  c = -ti; end
         2: begin s = -ti; c = -tn; end
         default: begin s = -tn; c = ti; end
      endcase
   endfunction

   // q42 down to q14, half up, clamped to +-1
   function automatic logic signed [OUT_W-1:0] round_q42(longint v);
      longint r;
      v += longint'(1) << 27;
      r = v >>> 28;
      if (r > ONE_Q14) r = ONE_Q14;
      if (r < -ONE_Q14) r = -ONE_Q14;
      return OUT_W'(r);
   endfunction

   function automatic matrix_type rotation_xyz(angles_type a);
      longint sx, cx, sy, cy, sz, cz;
      matrix_type m;
      angle_trig(a.ax, sx, cx);
      angle_trig(a.ay, sy, cy);
      angle_trig(a.az, sz, cz);
      m.r11 = round_q42(cy * cz * ONE_Q14);
      m.r12 = round_q42(-cy * sz * ONE_Q14);
      m.r13 = round_q42(sy * ONE_Q14 * ONE_Q14);
      m.r21 = round_q42(sx * sy * cz + cx * sz * ONE_Q14);
      m.r22 = round_q42(-sx * sy * sz + cx * cz * ONE_Q14);
      m.r23 = round_q42(-sx * cy * ONE_Q14);
      m.r31 = round_q42(-cx * sy * cz + sx * sz * ONE_Q14);
      m.r32 = round_q42(cx * sy * sz + sx * cz * ONE_Q14);
      m.r33 = round_q42(cx * cy * ONE_Q14);
      return m;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      case ($urandom_range(0, 5))
         0: return ANGLE_W'($urandom_range(0, 8) * 11520 - MAX_ANGLE);
         1: return ANGLE_W'($urandom_range(0, 16) * 5760 - MAX_ANGLE
                            + $urandom_range(0, 2) - 1);
         2: return ANGLE_W'($urandom);
         default: return ANGLE_W'(int'($urandom_range(0, 2 * MAX_ANGLE)) - MAX_ANGLE);
      endcase
   endfunction

   // driver
   initial begin
      req.valid = 1'b0;
      req.angle_x = '0;
      req.angle_y = '0;
      req.angle_z = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            expected_matrices.push_back(rotation_xyz(
               '{req.angle_x, req.angle_y, req.angle_z}));
            void'(pending_angles.pop_front());
         end
         if (req.valid && !req.ready) begin
            // hold the beat
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 16);
            req.valid <= 1'b0;
         end else if (pending_angles.size() > (req.valid && req.ready ? 0 : 0)) begin
            req.valid <= 1'b1;
            req.angle_x <= pending_angles[0].ax;
            req.angle_y <= pending_angles[0].ay;
            req.angle_z <= pending_angles[0].az;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   initial rsp.ready = 1'b0;

   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.r11, rsp.r12, rsp.r13, rsp.r21, rsp.r22, rsp.r23,
                    rsp.r31, rsp.r32, rsp.r33};
            if (expected_matrices.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected matrix beat %h", got);
            end else begin
               want = expected_matrices.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("matrix mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(0, 16);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      int edge_angles [9] = '{-92160, -69120, -46080, -23040, 0,
                              23040, 46080, 69120, 92160};
      for (int i = 0; i <= TAB_N; i++) quarter_sine[i] = sine_entry(i);
      // directed: extremes, quadrant boundaries, half-step rounding, raw bits
      for (int i = 0; i < 9; i++)
         pending_angles.push_back('{ANGLE_W'(edge_angles[i]),
            ANGLE_W'(edge_angles[(i + 3) % 9]), ANGLE_W'(edge_angles[(i + 6) % 9])});
      pending_angles.push_back('{ANGLE_W'(11), ANGLE_W'(-11), ANGLE_W'(23039)});
      pending_angles.push_back('{ANGLE_W'(23041), ANGLE_W'(-1), ANGLE_W'(1)});
      pending_angles.push_back('{18'h1FFFF, 18'h20000, 18'h3FFFF});
      pending_angles.push_back('{18'h20000, 18'h1FFFF, 18'h00000});
      pending_angles.push_back('{ANGLE_W'(23040), ANGLE_W'(23040), ANGLE_W'(23040)});
      pending_angles.push_back('{ANGLE_W'(11520), ANGLE_W'(34560), ANGLE_W'(-11520)});
      pending_angles.push_back('{18'h2AAAA, 18'h15555, 18'h3C3C3});
      repeat (800) pending_angles.push_back('{random_angle(), random_angle(),
                                                 random_angle()});
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_angles.size() < 120);
      calm = 1;
      wait (pending_angles.size() == 0);
      @(posedge clock);
      wait (expected_matrices.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_matrices.size() == 0)
         $display("[euler_to_rotation_matrix_top] OK");
      else
         $display("[euler_to_rotation_matrix_top] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[euler_to_rotation_matrix_top] ERROR");
      $finish;
   end

endmodule
